[sv/rgb2yuv_pkg.sv]
// ----------------------------------------------------------------------------
// rgb2yuv_pkg
// Shared types, constants and helpers for the RGB to YCbCr 4:2:0 converter.
// ----------------------------------------------------------------------------
package rgb2yuv_pkg;

  // Largest frame dimension and derived widths
  localparam int unsigned MaxDim = 4096;
  localparam int unsigned CntW   = $clog2(MaxDim);       // position counters
  localparam int unsigned DimW   = $clog2(MaxDim) + 1;   // frame size registers
  localparam int unsigned CfgIdxW = 4;

  localparam logic [DimW-1:0] MinDimVal   = DimW'(2);
  localparam logic [DimW-1:0] MaxDimVal   = DimW'(MaxDim);
  localparam logic [DimW-1:0] WidthReset  = DimW'(640);
  localparam logic [DimW-1:0] HeightReset = DimW'(480);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameWidth  = 4'd0,
    CfgFrameHeight = 4'd1
  } cfg_reg_e;

  // Chroma plane codes
  typedef enum logic [1:0] {
    PlaneNone = 2'd0,
    PlaneCb   = 2'd1,
    PlaneCr   = 2'd2
  } chroma_plane_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0]    luma;
    logic [7:0]    chroma;
    chroma_plane_e chroma_plane;
    logic          frame_end;
  } result_t;

  // Position-derived tags for one pixel
  typedef struct packed {
    chroma_plane_e plane;
    logic          frame_end;
  } pos_info_t;

  // Limit a programmed dimension to the supported range
  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v;
    if (v < MinDimVal) r = MinDimVal;
    else if (v > MaxDimVal) r = MaxDimVal;
    return r;
  endfunction

endpackage

[sv/rgb_to_yuv420_converter.sv]
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter
// RGB pixel stream to BT.601 luma with 4:2:0 interleaved chroma samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one RGB pixel per
//   transfer in raster order. Output channel (out_valid_o/out_ready_i/
//   out_data_o) gives one result per pixel: luma, and on even columns a Cb
//   (even rows) or Cr (odd rows) sample, plus a flag on the frame's last pixel.
//   Configuration channel (cfg_valid_i/cfg_ready_o) writes frame width
//   (index 0) and height (index 1); it is always ready and should only be
//   used while the block is empty.
//   The pipeline has two stages: pixel register, then result register.
//   Throughput is one pixel per cycle while the receiver takes results.
//   When the receiver stalls, the result register holds and the pixel
//   register fills; input ready falls only when both are occupied.
//   Reset empties the pipeline, zeroes the position counters and loads a
//   640 x 480 frame size.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_converter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  rgb2yuv_pkg::pixel_t             in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output rgb2yuv_pkg::result_t            out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rgb2yuv_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rgb2yuv_pkg::DimW-1:0]    cfg_data_i
);

  logic                   in_xfer, s2_ready;
  logic                   s1_v_q, s1_v_d, s2_v_q, s2_v_d;
  rgb2yuv_pkg::pixel_t    pix_q;
  rgb2yuv_pkg::pos_info_t info, info_q;
  rgb2yuv_pkg::result_t   res, res_q;

  assign cfg_ready_o = 1'b1;

  // Handshake: each stage loads when empty or when downstream takes its data
  assign s2_ready   = !s2_v_q || out_ready_i;
  assign in_ready_o = !s1_v_q || s2_ready;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign s1_v_d = in_xfer || (s1_v_q && !s2_ready);
  assign s2_v_d = (s1_v_q && s2_ready) || (s2_v_q && !out_ready_i);

  // Position tracking
  rgb2yuv_pos u_pos (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .adv_i       (in_xfer),
    .info_o      (info)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  // Pixel register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pix_q  <= in_data_i;
      info_q <= info;
    end
  end

  // Conversion
  rgb2yuv_csc u_csc (
    .pix_i  (pix_q),
    .info_i (info_q),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (s1_v_q && s2_ready) begin
      res_q <= res;
    end
  end

  assign out_valid_o = s2_v_q;
  assign out_data_o  = res_q;

  // Input only blocks when both stages hold data and the receiver stalls
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_v_q && s2_v_q && !out_ready_i)
    else $error("input stalled with room in the pipeline");

  // A held pixel is not lost while the result stage is blocked
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !s2_ready |=> s1_v_q && $stable(pix_q))
    else $error("pixel register dropped data under stall");

  // No chroma value without a chroma plane
  a_chroma_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.chroma_plane == rgb2yuv_pkg::PlaneNone
      |-> out_data_o.chroma == 8'd0)
    else $error("chroma nonzero on a luma-only result");

endmodule

[sv/rgb2yuv_pos.sv]
// ----------------------------------------------------------------------------
// rgb2yuv_pos
// Frame size registers and column/row tracking; tags each pixel with its
// chroma plane and end-of-frame flag.
// ----------------------------------------------------------------------------
module rgb2yuv_pos (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [rgb2yuv_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [rgb2yuv_pkg::DimW-1:0]        cfg_data_i,
  input  logic                                adv_i,
  output rgb2yuv_pkg::pos_info_t              info_o
);

  logic [rgb2yuv_pkg::DimW-1:0] width_q, height_q;
  logic [rgb2yuv_pkg::DimW-1:0] width_c, height_c;
  logic [rgb2yuv_pkg::CntW-1:0] col_q, col_d, row_q, row_d;
  logic                         last_col, last_row;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rgb2yuv_pkg::WidthReset;
      height_q <= rgb2yuv_pkg::HeightReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == rgb2yuv_pkg::CfgFrameWidth) width_q <= cfg_data_i;
      if (cfg_index_i == rgb2yuv_pkg::CfgFrameHeight) height_q <= cfg_data_i;
    end
  end

  assign width_c  = rgb2yuv_pkg::clamp_dim(width_q);
  assign height_c = rgb2yuv_pkg::clamp_dim(height_q);

  // Last column/row; a counter past a shrunk bound also counts as last
  assign last_col = (rgb2yuv_pkg::DimW'(col_q) + rgb2yuv_pkg::DimW'(1)) >= width_c;
  assign last_row = (rgb2yuv_pkg::DimW'(row_q) + rgb2yuv_pkg::DimW'(1)) >= height_c;

  // Counter advance
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (adv_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + rgb2yuv_pkg::CntW'(1);
      end else begin
        col_d = col_q + rgb2yuv_pkg::CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Tags: chroma on even columns, Cb on even rows and Cr on odd rows
  always_comb begin
    info_o.frame_end = last_col & last_row;
    if (col_q[0]) begin
      info_o.plane = rgb2yuv_pkg::PlaneNone;
    end else if (row_q[0]) begin
      info_o.plane = rgb2yuv_pkg::PlaneCr;
    end else begin
      info_o.plane = rgb2yuv_pkg::PlaneCb;
    end
  end

  // Column wraps to zero after the last column
  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && last_col |=> col_q == '0)
    else $error("column counter did not wrap");

  // Row only moves when the column wraps
  a_row_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && !last_col |=> $stable(row_q))
    else $error("row counter moved mid-row");

endmodule

[sv/rgb2yuv_csc.sv]
// ----------------------------------------------------------------------------
// rgb2yuv_csc
// Integer BT.601 colour space conversion of one pixel (luma plus the
// selected chroma sample).
// ----------------------------------------------------------------------------
module rgb2yuv_csc (
  input  rgb2yuv_pkg::pixel_t    pix_i,
  input  rgb2yuv_pkg::pos_info_t info_i,
  output rgb2yuv_pkg::result_t   res_o
);

  logic [15:0] r, g, b;
  logic [15:0] y_sum, cb_sum, cr_sum;

  assign r = 16'(pix_i.red);
  assign g = 16'(pix_i.green);
  assign b = 16'(pix_i.blue);

  // Luma: (66R + 129G + 25B + 128) >> 8, plus 16
  assign y_sum = 16'd66 * r + 16'd129 * g + 16'd25 * b + 16'd128;

  // Chroma sums carry the +128 rounding and a +32768 bias; the true value
  // stays within 16 bits, so modulo arithmetic is exact
  assign cb_sum = 16'd32896 + 16'd112 * b - 16'd38 * r - 16'd74 * g;
  assign cr_sum = 16'd32896 + 16'd112 * r - 16'd94 * g - 16'd18 * b;

  always_comb begin
    res_o.luma         = y_sum[15:8] + 8'd16;
    res_o.chroma_plane = info_i.plane;
    res_o.frame_end    = info_i.frame_end;
    case (info_i.plane)
      rgb2yuv_pkg::PlaneCb: res_o.chroma = cb_sum[15:8];
      rgb2yuv_pkg::PlaneCr: res_o.chroma = cr_sum[15:8];
      default:              res_o.chroma = 8'd0;
    endcase
  end

endmodule

[dv/tb_rgb_to_yuv420_converter.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_to_yuv420_converter
// Self-checking bench for the RGB to YCbCr 4:2:0 converter. A short stimulus
// table covers colour extremes, both chroma planes, frame-end flagging,
// clamped and odd frame sizes and ignored register writes. Random phases
// follow, each with a fresh frame size and its own idling pattern on the
// pixel and result channels. Every result is compared field by field with its
// typed table value or an in-bench model of the conversion and position counters.
// ----------------------------------------------------------------------------
module tb_rgb_to_yuv420_converter;

  localparam int NumDirected   = 25;
  localparam int NumPhases     = 8;
  localparam int ItemsPerPhase = 86;
  localparam int DrainCycles   = 8;
  localparam int UnusedIdxLo   = 2;
  localparam int UnusedIdxHi   = 15;
  localparam logic [rgb2yuv_pkg::CfgIdxW-1:0] SpareIdxLo = rgb2yuv_pkg::CfgIdxW'(UnusedIdxLo);
  localparam logic [rgb2yuv_pkg::CfgIdxW-1:0] SpareIdxHi = rgb2yuv_pkg::CfgIdxW'(UnusedIdxHi);

  // One row of the stimulus table: a pixel or a register write
  typedef struct {
    bit                                 is_cfg;
    logic [rgb2yuv_pkg::CfgIdxW-1:0]    idx;
    logic [rgb2yuv_pkg::DimW-1:0]       val;
    rgb2yuv_pkg::pixel_t                pix;
    bit                                 known;
    rgb2yuv_pkg::result_t               res;
  } stim_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  rgb2yuv_pkg::pixel_t             in_data = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  rgb2yuv_pkg::result_t            out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [rgb2yuv_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [rgb2yuv_pkg::DimW-1:0]    cfg_data = '0;

  // Idling controls, in percent of cycles
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatch_count = 0;

  // Model state: frame size registers and position of the next pixel
  logic [rgb2yuv_pkg::DimW-1:0] width_reg = rgb2yuv_pkg::WidthReset;
  logic [rgb2yuv_pkg::DimW-1:0] height_reg = rgb2yuv_pkg::HeightReset;
  int unsigned                  col_pos = 0;
  int unsigned                  row_pos = 0;

  rgb2yuv_pkg::result_t pending_yuv_q[$];
  stim_row_t            directed[NumDirected];

  always #6 clk = ~clk;

  rgb_to_yuv420_converter dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Effective frame dimension after range limiting
  function automatic int unsigned limit_dim(logic [rgb2yuv_pkg::DimW-1:0] v);
    if (v < 2) return 2;
    if (v > rgb2yuv_pkg::MaxDim) return rgb2yuv_pkg::MaxDim;
    return int'(v);
  endfunction

  // Floor of (s + 128) / 256, offset by 128, wrapped to a byte
  function automatic logic [7:0] chroma_byte(int s);
    return 8'((s + 128 + 32768) >> 8);
  endfunction

  // Convert one pixel and advance the raster position
  function automatic rgb2yuv_pkg::result_t predict_yuv(rgb2yuv_pkg::pixel_t p);
    int                   r;
    int                   g;
    int                   b;
    int unsigned          w;
    int unsigned          h;
    bit                   end_col;
    bit                   end_row;
    rgb2yuv_pkg::result_t res;
    r = int'(p.red);
    g = int'(p.green);
    b = int'(p.blue);
    w = limit_dim(width_reg);
    h = limit_dim(height_reg);
    end_col = (col_pos + 1) >= w;
    end_row = (row_pos + 1) >= h;
    res.luma = 8'(((66 * r + 129 * g + 25 * b + 128) >> 8) + 16);
    res.chroma = '0;
    res.chroma_plane = rgb2yuv_pkg::PlaneNone;
    // chroma on even columns: Cb on even rows, Cr on odd rows
    if (col_pos % 2 == 0) begin
      if (row_pos % 2 == 0) begin
        res.chroma = chroma_byte(-38 * r - 74 * g + 112 * b);
        res.chroma_plane = rgb2yuv_pkg::PlaneCb;
      end else begin
        res.chroma = chroma_byte(112 * r - 94 * g - 18 * b);
        res.chroma_plane = rgb2yuv_pkg::PlaneCr;
      end
    end
    res.frame_end = end_col && end_row;
    if (end_col) begin
      col_pos = 0;
      row_pos = end_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return res;
  endfunction

  function automatic void apply_cfg(logic [rgb2yuv_pkg::CfgIdxW-1:0] idx,
                                    logic [rgb2yuv_pkg::DimW-1:0] val);
    case (idx)
      rgb2yuv_pkg::CfgFrameWidth:  width_reg = val;
      rgb2yuv_pkg::CfgFrameHeight: height_reg = val;
      default: ;
    endcase
  endfunction

  // Table row builders
  function automatic stim_row_t row_px(int r, int g, int b);
    stim_row_t row;
    row = '{default: '0};
    row.pix = '{red: 8'(r), green: 8'(g), blue: 8'(b)};
    return row;
  endfunction

  function automatic stim_row_t row_pxk(int r, int g, int b, int y, int c,
                                        rgb2yuv_pkg::chroma_plane_e plane, bit fe);
    stim_row_t row;
    row = row_px(r, g, b);
    row.known = 1'b1;
    row.res = '{luma: 8'(y), chroma: 8'(c), chroma_plane: plane, frame_end: fe};
    return row;
  endfunction

  function automatic stim_row_t row_cfg(logic [rgb2yuv_pkg::CfgIdxW-1:0] idx,
                                        logic [rgb2yuv_pkg::DimW-1:0] val);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.val = val;
    return row;
  endfunction

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [rgb2yuv_pkg::DimW-1:0] pick_dim();
    case ($urandom_range(9))
      0: return '0;
      1: return rgb2yuv_pkg::DimW'(1);
      2: return '1;
      3: return rgb2yuv_pkg::DimW'(rgb2yuv_pkg::MaxDim);
      4: return rgb2yuv_pkg::DimW'($urandom);
      default: return rgb2yuv_pkg::DimW'($urandom_range(2, 9));
    endcase
  endfunction

  // Pixel transfer; the expectation is the typed one where given
  task automatic send_pixel(rgb2yuv_pkg::pixel_t p, bit known, rgb2yuv_pkg::result_t typed);
    rgb2yuv_pkg::result_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    pred = predict_yuv(p);
    pending_yuv_q.push_back(known ? typed : pred);
    @(posedge clk);
  endtask

  // Register write, only once the pipeline has drained
  task automatic write_cfg(logic [rgb2yuv_pkg::CfgIdxW-1:0] idx,
                           logic [rgb2yuv_pkg::DimW-1:0] val);
    in_valid <= 1'b0;
    while (pending_yuv_q.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    apply_cfg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  // Result channel back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Result check; signals are stable at the falling edge
  always @(negedge clk) begin
    rgb2yuv_pkg::result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_yuv_q.size() == 0) begin
        $error("result with nothing expected: %h", out_data);
        mismatch_count++;
      end else begin
        exp_res = pending_yuv_q.pop_front();
        if (out_data.luma !== exp_res.luma) begin
          $error("luma: expected %0d, got %0d", exp_res.luma, out_data.luma);
          mismatch_count++;
        end
        if (out_data.chroma !== exp_res.chroma) begin
          $error("chroma: expected %0d, got %0d", exp_res.chroma, out_data.chroma);
          mismatch_count++;
        end
        if (out_data.chroma_plane !== exp_res.chroma_plane) begin
          $error("chroma_plane: expected %0d, got %0d",
                 exp_res.chroma_plane, out_data.chroma_plane);
          mismatch_count++;
        end
        if (out_data.frame_end !== exp_res.frame_end) begin
          $error("frame_end: expected %0d, got %0d",
                 exp_res.frame_end, out_data.frame_end);
          mismatch_count++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    rgb2yuv_pkg::pixel_t rand_pix;
    rgb2yuv_pkg::result_t no_res;
    no_res = '0;
    directed = '{
      row_pxk(0, 0, 0, 16, 128, rgb2yuv_pkg::PlaneCb, 1'b0),
      row_pxk(255, 255, 255, 235, 0, rgb2yuv_pkg::PlaneNone, 1'b0),
      row_pxk(0, 0, 255, 41, 240, rgb2yuv_pkg::PlaneCb, 1'b0),
      row_px(255, 0, 0),
      row_cfg(rgb2yuv_pkg::CfgFrameWidth, '0),                  // below range, used as 2
      row_cfg(rgb2yuv_pkg::CfgFrameHeight, rgb2yuv_pkg::DimW'(1)), // shrinks mid-frame
      row_px(0, 255, 0),
      row_pxk(255, 0, 0, 82, 240, rgb2yuv_pkg::PlaneCr, 1'b0),
      row_pxk(255, 255, 255, 235, 0, rgb2yuv_pkg::PlaneNone, 1'b1),
      row_pxk(0, 0, 0, 16, 128, rgb2yuv_pkg::PlaneCb, 1'b0),
      row_px(0, 255, 255),
      row_cfg(SpareIdxHi, '1),                                   // unknown index, ignored
      row_cfg(rgb2yuv_pkg::CfgFrameWidth, '1),                   // above range, used as max
      row_cfg(rgb2yuv_pkg::CfgFrameHeight, '1),
      row_px(0, 255, 255),
      row_px(255, 255, 0),
      row_cfg(rgb2yuv_pkg::CfgFrameWidth, rgb2yuv_pkg::DimW'(3)), // odd width
      row_cfg(rgb2yuv_pkg::CfgFrameHeight, rgb2yuv_pkg::DimW'(3)),
      row_px(128, 128, 128),
      row_px(255, 0, 255),
      row_px(128, 64, 1),
      row_px(255, 255, 0),
      row_cfg(SpareIdxLo, '0),
      row_cfg(rgb2yuv_pkg::CfgFrameWidth, rgb2yuv_pkg::DimW'(rgb2yuv_pkg::MaxDim)),
      row_cfg(rgb2yuv_pkg::CfgFrameHeight, rgb2yuv_pkg::DimW'(2))
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < NumDirected; i++) begin
      if (directed[i].is_cfg) begin
        write_cfg(directed[i].idx, directed[i].val);
      end else begin
        send_pixel(directed[i].pix, directed[i].known, directed[i].res);
      end
    end

    // random phases, each with its own frame size and idling
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 61; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 61; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      write_cfg(rgb2yuv_pkg::CfgFrameWidth, pick_dim());
      write_cfg(rgb2yuv_pkg::CfgFrameHeight, pick_dim());
      if ($urandom_range(1) == 1) begin
        write_cfg(rgb2yuv_pkg::CfgIdxW'($urandom_range(UnusedIdxHi, UnusedIdxLo)),
                  rgb2yuv_pkg::DimW'($urandom));
      end
      repeat (ItemsPerPhase) begin
        rand_pix.red   = rand_channel();
        rand_pix.green = rand_channel();
        rand_pix.blue  = rand_channel();
        send_pixel(rand_pix, 1'b0, no_res);
      end
    end

    // drain
    in_valid <= 1'b0;
    while (pending_yuv_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

endmodule
